FILE: rtl/arm_halfword_signed_transfer_macros.svh
// Assertion helpers for the halfword transfer block.
`ifndef ARM_HALFWORD_SIGNED_TRANSFER_MACROS_SVH
`define ARM_HALFWORD_SIGNED_TRANSFER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AHST_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ahst: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define AHST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ahst: next-cycle check failed");

`endif

FILE: rtl/ahst_pkg.sv
package ahst_pkg;

   // Input item kinds
   typedef enum logic {
      REQ_ISSUE = 1'b0,
      REQ_DATA  = 1'b1
   } req_kind_type;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_REG   = 2'd2
   } result_kind_type;

   // Opcode bit positions
   localparam int unsigned BIT_PRE  = 24;
   localparam int unsigned BIT_UP   = 23;
   localparam int unsigned BIT_IMM  = 22;
   localparam int unsigned BIT_WB   = 21;
   localparam int unsigned BIT_LOAD = 20;
   localparam int unsigned BIT_SGN  = 6;
   localparam int unsigned BIT_HALF = 5;

   // One classified command: a first result, plus an optional base writeback
   typedef struct packed {
      result_kind_type kind;
      logic            size;
      logic [31:0]     addr;
      logic [31:0]     data;
      logic [3:0]      reg_idx;
      logic            has_wb;
      logic [31:0]     wb_value;
      logic [3:0]      wb_idx;
   } cmd_type;

endpackage

FILE: rtl/arm_halfword_signed_transfer.sv
// Halfword and signed data transfer execute unit (LDRH/STRH/LDRSB/LDRSH).
// Input queue side: push/full. An item is either an instruction issue
// (req_type low: opcode plus base, offset and source register values) or
// a bus read data return (req_type high: req_read_data).
// Result queue side: empty/pop. The oldest result sits on the rsp_ ports
// while empty is low; rsp_last marks the final result of an input item.
// A store gives a bus write and, if enabled, a base register write. A load
// gives a bus read; its register write (and deferred base writeback)
// follows the later data return. A data return with no load pending
// gives nothing.
// The first result of an item is visible in the cycle after its
// transfer when no older result is waiting.
// Throughput: one input item per cycle while the command queue
// (QueueDepth entries) has room; results leave at one per cycle while
// pop is high, so an item with two results takes two pops to drain.
// A stalled result side fills the queue, then full rises and holds inputs.
// Reset clears the queue, the result phase and the pending-load flag.
module arm_halfword_signed_transfer #(
   parameter int unsigned QueueDepth = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_type,
   input  logic [31:0] req_opcode,
   input  logic [31:0] req_base_value,
   input  logic [31:0] req_offset_reg_value,
   input  logic [31:0] req_source_value,
   input  logic [15:0] req_read_data,
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_result_kind,
   output logic        rsp_access_size,
   output logic [31:0] rsp_target_address,
   output logic [31:0] rsp_payload,
   output logic [3:0]  rsp_reg_index,
   output logic        rsp_last
);
   import ahst_pkg::*;

   `include "arm_halfword_signed_transfer_macros.svh"

   logic    accept;
   logic    cmd_valid;
   cmd_type cmd;
   cmd_type head;
   logic    q_empty;
   logic    q_pop;
   logic    rsp_xfer;
   logic    rsp_is_read;
   logic    rsp_is_reg;

   assign accept = push && !full;

   // Front: decode, address, pending load
   ahst_front u_front (
      .clock                (clock),
      .reset                (reset),
      .accept               (accept),
      .req_type             (req_type),
      .req_opcode           (req_opcode),
      .req_base_value       (req_base_value),
      .req_offset_reg_value (req_offset_reg_value),
      .req_source_value     (req_source_value),
      .req_read_data        (req_read_data),
      .cmd_valid            (cmd_valid),
      .cmd                  (cmd)
   );

   // Command queue between front and back
   ahst_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept && cmd_valid),
      .wr_data (cmd),
      .rd_en   (q_pop),
      .rd_data (head),
      .full    (full),
      .empty   (q_empty)
   );

   // Back: serialize results
   ahst_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .q_empty            (q_empty),
      .q_pop              (q_pop),
      .pop                (pop),
      .empty              (empty),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_access_size    (rsp_access_size),
      .rsp_target_address (rsp_target_address),
      .rsp_payload        (rsp_payload),
      .rsp_reg_index      (rsp_reg_index),
      .rsp_last           (rsp_last)
   );

   // Checks
   assign rsp_xfer    = pop && !empty;
   assign rsp_is_read = (rsp_result_kind == KIND_READ);
   assign rsp_is_reg  = (rsp_result_kind == KIND_REG);

   `AHST_ASSERT_NOW(a_full_not_empty, clock, reset, full, !empty)
   `AHST_ASSERT_NOW(a_read_is_last, clock, reset, !empty && rsp_is_read, rsp_last)
   `AHST_ASSERT_NEXT(a_wb_follows, clock, reset, rsp_xfer && !rsp_last, !empty && rsp_is_reg && rsp_last)

endmodule

FILE: rtl/ahst_front.sv
module ahst_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic            req_type,
   input  logic [31:0]     req_opcode,
   input  logic [31:0]     req_base_value,
   input  logic [31:0]     req_offset_reg_value,
   input  logic [31:0]     req_source_value,
   input  logic [15:0]     req_read_data,
   output logic            cmd_valid,
   output ahst_pkg::cmd_type cmd
);
   import ahst_pkg::*;

   // Pending load state
   logic        load_pending_ff, load_pending_in;
   logic        pend_wb_ff, pend_wb_in;
   logic [3:0]  pend_dest_ff;
   logic        pend_half_ff;
   logic        pend_sgn_ff;
   logic        pend_odd_ff;
   logic [3:0]  pend_base_idx_ff;
   logic [31:0] pend_base_addr_ff;

   // Opcode fields
   logic        pre, up, imm, wbit, ld, sgn, half;
   logic [3:0]  rn, rd;
   logic [31:0] off, stepped, addr;
   logic        wb;
   logic [31:0] load_val;
   logic [15:0] d;

   assign pre  = req_opcode[BIT_PRE];
   assign up   = req_opcode[BIT_UP];
   assign imm  = req_opcode[BIT_IMM];
   assign wbit = req_opcode[BIT_WB];
   assign ld   = req_opcode[BIT_LOAD];
   assign sgn  = req_opcode[BIT_SGN];
   assign half = req_opcode[BIT_HALF];
   assign rn   = req_opcode[19:16];
   assign rd   = req_opcode[15:12];

   // Address generation
   assign off     = imm ? {24'h0, req_opcode[11:8], req_opcode[3:0]} : req_offset_reg_value;
   assign stepped = up ? (req_base_value + off) : (req_base_value - off);
   assign addr    = pre ? stepped : req_base_value;
   assign wb      = (!pre || wbit) && !(ld && (rd == rn));

   // Load data alignment and extension
   assign d = req_read_data;
   always_comb begin
      if (pend_half_ff) begin
         if (pend_sgn_ff)
            load_val = pend_odd_ff ? {{24{d[15]}}, d[15:8]} : {{16{d[15]}}, d};
         else if (pend_odd_ff)
            load_val = {d[7:0], 16'h0, d[15:8]};
         else
            load_val = {16'h0, d};
      end else begin
         load_val = pend_sgn_ff ? {{24{d[7]}}, d[7:0]} : {24'h0, d[7:0]};
      end
   end

   // Classify the item into a command
   always_comb begin
      cmd             = '0;
      cmd_valid       = 1'b0;
      load_pending_in = load_pending_ff;
      pend_wb_in      = pend_wb_ff;
      if (req_type == REQ_DATA) begin
         cmd_valid    = load_pending_ff;
         cmd.kind     = KIND_REG;
         cmd.data     = load_val;
         cmd.reg_idx  = pend_dest_ff;
         cmd.has_wb   = pend_wb_ff;
         cmd.wb_value = pend_base_addr_ff;
         cmd.wb_idx   = pend_base_idx_ff;
         if (load_pending_ff) begin
            load_pending_in = 1'b0;
            pend_wb_in      = 1'b0;
         end
      end else begin
         cmd_valid = 1'b1;
         cmd.size  = half;
         cmd.addr  = addr;
         if (ld) begin
            cmd.kind        = KIND_READ;
            load_pending_in = 1'b1;
            pend_wb_in      = wb;
         end else begin
            cmd.kind        = KIND_WRITE;
            cmd.data        = half ? {16'h0, req_source_value[15:0]}
                                   : {24'h0, req_source_value[7:0]};
            cmd.has_wb      = wb;
            cmd.wb_value    = stepped;
            cmd.wb_idx      = rn;
            load_pending_in = 1'b0;
            pend_wb_in      = 1'b0;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         load_pending_ff <= 1'b0;
         pend_wb_ff      <= 1'b0;
      end else if (accept) begin
         load_pending_ff <= load_pending_in;
         pend_wb_ff      <= pend_wb_in;
      end
   end

   // Load context, captured on each load issue
   always_ff @(posedge clock) begin
      if (accept && (req_type == REQ_ISSUE) && ld) begin
         pend_dest_ff      <= rd;
         pend_half_ff      <= half;
         pend_sgn_ff       <= sgn;
         pend_odd_ff       <= addr[0];
         pend_base_idx_ff  <= rn;
         pend_base_addr_ff <= stepped;
      end
   end

endmodule

FILE: rtl/ahst_queue.sv
module ahst_queue #(
   parameter int unsigned Depth = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  ahst_pkg::cmd_type wr_data,
   input  logic              rd_en,
   output ahst_pkg::cmd_type rd_data,
   output logic              full,
   output logic              empty
);
   import ahst_pkg::*;

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   cmd_type          mem_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CntW'(Depth));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr)
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_rd)
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_wr && !do_rd)
         count_in = count_ff + 1'b1;
      else if (do_rd && !do_wr)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_wr)
         mem_ff[wr_ptr_ff] <= wr_data;
   end

endmodule

FILE: rtl/ahst_back.sv
module ahst_back (
   input  logic              clock,
   input  logic              reset,
   input  ahst_pkg::cmd_type head,
   input  logic              q_empty,
   output logic              q_pop,
   input  logic              pop,
   output logic              empty,
   output logic [1:0]        rsp_result_kind,
   output logic              rsp_access_size,
   output logic [31:0]       rsp_target_address,
   output logic [31:0]       rsp_payload,
   output logic [3:0]        rsp_reg_index,
   output logic              rsp_last
);
   import ahst_pkg::*;

   // Low: first result of the head command; high: its base writeback
   logic phase_ff, phase_in;
   logic xfer;

   assign empty = q_empty;
   assign xfer  = pop && !q_empty;

   // Result select
   always_comb begin
      if (phase_ff) begin
         rsp_result_kind    = KIND_REG;
         rsp_access_size    = 1'b0;
         rsp_target_address = '0;
         rsp_payload        = head.wb_value;
         rsp_reg_index      = head.wb_idx;
         rsp_last           = 1'b1;
      end else begin
         rsp_result_kind    = head.kind;
         rsp_access_size    = head.size;
         rsp_target_address = head.addr;
         rsp_payload        = head.data;
         rsp_reg_index      = head.reg_idx;
         rsp_last           = !head.has_wb;
      end
   end

   // Advance through the command's results
   always_comb begin
      phase_in = phase_ff;
      q_pop    = 1'b0;
      if (xfer) begin
         if (!phase_ff && head.has_wb) begin
            phase_in = 1'b1;
         end else begin
            phase_in = 1'b0;
            q_pop    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         phase_ff <= 1'b0;
      else
         phase_ff <= phase_in;
   end

endmodule
